// ----- hw/rtl/bptm_pkg.sv -----
`default_nettype none

package bptm_pkg;

    localparam int TILE       = 4;
    localparam int MAX_PLANES = 8;
    localparam int ACT_WIDTH  = 16;

    localparam int PLANE_W  = 3;
    localparam int ROW_W    = 2;
    localparam int NPLANE_W = 4;
    localparam int OUT_W    = 32;

    // one plane's masked sum of TILE activations
    localparam int PSUM_W = ACT_WIDTH + $clog2(TILE);
    // sum over planes of psum << p, cannot overflow at this width
    localparam int ACC_W  = PSUM_W + MAX_PLANES;

    localparam logic [NPLANE_W-1:0] ACTIVE_PLANES_RST = NPLANE_W'(MAX_PLANES);

    // s_axis_tdata field offsets
    localparam int PLANE_LSB = 0;
    localparam int ROW_LSB   = PLANE_LSB + PLANE_W;
    localparam int BITS_LSB  = ROW_LSB + ROW_W;
    localparam int ACT_LSB   = BITS_LSB + TILE;
    localparam int S_FIELD_W = ACT_LSB + TILE * ACT_WIDTH;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = TILE * OUT_W;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ACT  = 1'b1;

    typedef logic [TILE-1:0]                  mask_t;
    typedef mask_t [MAX_PLANES-1:0][TILE-1:0] store_t;
    typedef logic [MAX_PLANES-1:0][TILE-1:0]  col_bits_t;
    typedef logic [TILE-1:0][ACT_WIDTH-1:0]   act_row_t;

    typedef struct packed {
        logic                load_en;
        logic [NPLANE_W-1:0] n_planes;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bit_plane_tile_matmul.sv -----
`default_nettype none

// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser cmd, tdata load fields or activation row
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata out0..out3
// cfg      in   cfg_wr_en                    cfg_wr_data active_planes
//
// One transaction accepted per cycle while s_axis_tready is high; loads and activations alike.
// An activation row reaches m_axis after it is accepted in this order:
// per-plane partial sums register, then the shift-add lands in the output register.
// Loads write the weight store at acceptance and produce no output.
// Reset clears the weight store, the pipeline valids and sets active_planes to 8.
// A held output stalls s_axis only once the partial-sum stage is also full.
module bit_plane_tile_matmul (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // plane[2:0], weight_row[4:3], row_mask[8:5], act0..act3 16b each from bit 9, zero pad
    input  wire logic [bptm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out0[31:0], out1[63:32], out2[95:64], out3[127:96]
    output logic [bptm_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bptm_pkg::NPLANE_W-1:0]    cfg_wr_data
);
    import bptm_pkg::*;

    logic [NPLANE_W-1:0]  active_planes_reg;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic       out_free, s1_adv, in_xfer, act_in, load_in;
    store_t     masks;
    act_row_t   act;
    lane_ctrl_t lane_ctrl;
    logic signed [ACC_W-1:0] lane_acc [TILE];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign act_in        = in_xfer && (s_axis_tuser == CMD_ACT);
    assign load_in       = in_xfer && (s_axis_tuser == CMD_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_planes_reg <= ACTIVE_PLANES_RST;
        end else if (cfg_wr_en) begin
            active_planes_reg <= cfg_wr_data;
        end
    end

    bptm_weight_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (load_in),
        .wr_plane (s_axis_tdata[PLANE_LSB +: PLANE_W]),
        .wr_row   (s_axis_tdata[ROW_LSB +: ROW_W]),
        .wr_bits  (s_axis_tdata[BITS_LSB +: TILE]),
        .masks    (masks)
    );

    always_comb begin
        for (int k = 0; k < TILE; k++) begin
            act[k] = s_axis_tdata[ACT_LSB + k*ACT_WIDTH +: ACT_WIDTH];
        end
    end

    assign lane_ctrl.load_en  = act_in;
    assign lane_ctrl.n_planes = active_planes_reg;

    for (genvar j = 0; j < TILE; j++) begin : g_lane
        col_bits_t col_bits;

        always_comb begin
            for (int p = 0; p < MAX_PLANES; p++) begin
                for (int k = 0; k < TILE; k++) begin
                    col_bits[p][k] = masks[p][k][j];
                end
            end
        end

        bptm_lane u_lane (
            .aclk     (aclk),
            .ctrl     (lane_ctrl),
            .col_bits (col_bits),
            .act      (act),
            .acc      (lane_acc[j])
        );
    end

    // merge: sign-extend each column and pack into the output register
    always_comb begin
        for (int j = 0; j < TILE; j++) begin
            m_data_next[j*OUT_W +: OUT_W] = OUT_W'(lane_acc[j]);
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (act_in) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are held");

    a_out_from_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("output valid without a partial-sum stage entry");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_in && !s1_valid_reg) |=> !s1_valid_reg)
        else $error("load transaction entered the compute pipeline");

endmodule

`default_nettype wire

// ----- hw/rtl/bptm_weight_store.sv -----
`default_nettype none

module bptm_weight_store (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    wr_en,
    input  wire logic [bptm_pkg::PLANE_W-1:0] wr_plane,
    input  wire logic [bptm_pkg::ROW_W-1:0]   wr_row,
    input  wire bptm_pkg::mask_t         wr_bits,
    output bptm_pkg::store_t             masks
);
    import bptm_pkg::*;

    store_t store_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= '0;
        end else if (wr_en) begin
            store_reg[wr_plane][wr_row] <= wr_bits;
        end
    end

    assign masks = store_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bptm_lane.sv -----
`default_nettype none

// One output column: registered per-plane partial sums, then shift-add.
module bptm_lane (
    input  wire logic                   aclk,
    input  wire bptm_pkg::lane_ctrl_t   ctrl,
    input  wire bptm_pkg::col_bits_t    col_bits,
    input  wire bptm_pkg::act_row_t     act,
    output logic signed [bptm_pkg::ACC_W-1:0] acc
);
    import bptm_pkg::*;

    logic signed [PSUM_W-1:0] psum_reg  [MAX_PLANES];
    logic signed [PSUM_W-1:0] psum_next [MAX_PLANES];

    always_comb begin
        for (int p = 0; p < MAX_PLANES; p++) begin
            psum_next[p] = '0;
            for (int k = 0; k < TILE; k++) begin
                if (col_bits[p][k]) begin
                    psum_next[p] = psum_next[p] + PSUM_W'($signed(act[k]));
                end
            end
            // planes at or above the active count add nothing
            if (NPLANE_W'(p) >= ctrl.n_planes) begin
                psum_next[p] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_en) begin
            psum_reg <= psum_next;
        end
    end

    always_comb begin
        acc = '0;
        for (int p = 0; p < MAX_PLANES; p++) begin
            acc = acc + (ACC_W'(psum_reg[p]) <<< p);
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bptm_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASE_ITEMS     = 108;
    localparam int N_PHASES        = 6;
    localparam int N_DIRECTED      = 21;

    typedef logic [TILE-1:0][OUT_W-1:0] out_row_t;

    typedef struct {
        logic                cmd;
        logic [PLANE_W-1:0]  plane;
        logic [ROW_W-1:0]    wrow;
        mask_t               bits;
        act_row_t            acts;
    } item_t;

    typedef enum logic [1:0] {RK_CFG, RK_LOAD, RK_ACT} row_kind_t;

    // bits doubles as the plane count on config rows
    typedef struct {
        row_kind_t           kind;
        logic [3:0]          bits;
        logic [PLANE_W-1:0]  plane;
        logic [ROW_W-1:0]    wrow;
        act_row_t            acts;
        bit                  typed;
        out_row_t            want;
    } plan_row_t;

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic                    cfg_wr_en     = 1'b0;
    logic [NPLANE_W-1:0]     cfg_wr_data   = '0;

    // shadow of the block: weight masks and plane count
    mask_t                   wmask [MAX_PLANES][TILE];
    logic [NPLANE_W-1:0]     planes_cfg;
    out_row_t                pending_rows [$];
    int                      n_fail   = 0;
    int                      idle_cyc = 0;
    bit                      idle_on  = 1'b1;

    // act rows are written act3 first; want rows out3 first
    plan_row_t dir_plan [N_DIRECTED] = '{
        '{RK_ACT,  4'hF, 3'd7, 2'd3, {16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF}, 1'b1, '0},
        '{RK_LOAD, 4'hF, 3'd0, 2'd0, {4{16'hFFFF}}, 1'b0, '0},
        '{RK_LOAD, 4'hF, 3'd0, 2'd1, {4{16'h8000}}, 1'b0, '0},
        '{RK_LOAD, 4'hF, 3'd0, 2'd2, {4{16'h7FFF}}, 1'b0, '0},
        '{RK_LOAD, 4'hF, 3'd0, 2'd3, '0, 1'b0, '0},
        '{RK_ACT,  4'h0, 3'd0, 2'd0, {4{16'h7FFF}}, 1'b1, {4{32'd131068}}},
        '{RK_ACT,  4'hF, 3'd7, 2'd3, {4{16'h8000}}, 1'b1, {4{32'hFFFE_0000}}},
        '{RK_LOAD, 4'h1, 3'd7, 2'd0, '0, 1'b0, '0},
        '{RK_ACT,  4'h0, 3'd0, 2'd0, {16'h0, 16'h0, 16'h0, 16'h8000}, 1'b0, '0},
        '{RK_LOAD, 4'hA, 3'd3, 2'd2, '0, 1'b0, '0},
        '{RK_LOAD, 4'h5, 3'd5, 2'd1, {4{16'h5A5A}}, 1'b0, '0},
        '{RK_LOAD, 4'hC, 3'd6, 2'd3, '0, 1'b0, '0},
        '{RK_CFG,  4'd0, 3'd0, 2'd0, '0, 1'b0, '0},
        '{RK_ACT,  4'h0, 3'd0, 2'd0, {4{16'h7FFF}}, 1'b1, '0},
        '{RK_CFG,  4'd15, 3'd0, 2'd0, '0, 1'b0, '0},
        '{RK_ACT,  4'h6, 3'd2, 2'd1, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001}, 1'b0, '0},
        '{RK_CFG,  4'd1, 3'd0, 2'd0, '0, 1'b0, '0},
        '{RK_ACT,  4'h0, 3'd0, 2'd0, {16'd4, 16'd3, 16'd2, 16'd1}, 1'b1, {4{32'd10}}},
        '{RK_CFG,  4'd8, 3'd0, 2'd0, '0, 1'b0, '0},
        '{RK_LOAD, 4'h0, 3'd0, 2'd0, '0, 1'b0, '0},
        '{RK_ACT,  4'h9, 3'd4, 2'd2, {16'h1111, 16'h8001, 16'hFFFE, 16'h7FFE}, 1'b0, '0}
    };

    bit_plane_tile_matmul dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // out[j] = sum over active planes of (masked activation sum) << plane, mod 2^32
    function automatic out_row_t matmul_row(input act_row_t acts);
        out_row_t    r;
        logic [31:0] acc;
        logic [31:0] part;
        int          n;
        n = (planes_cfg > MAX_PLANES) ? MAX_PLANES : int'(planes_cfg);
        for (int j = 0; j < TILE; j++) begin
            acc = '0;
            for (int p = 0; p < n; p++) begin
                part = '0;
                for (int k = 0; k < TILE; k++) begin
                    if (wmask[p][k][j])
                        part += {{(32-ACT_WIDTH){acts[k][ACT_WIDTH-1]}}, acts[k]};
                end
                acc += part << p;
            end
            r[j] = acc;
        end
        return r;
    endfunction

    function automatic logic [15:0] rand_act();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.cmd   = ($urandom_range(0, 99) < 40) ? CMD_LOAD : CMD_ACT;
        it.plane = PLANE_W'($urandom);
        it.wrow  = ROW_W'($urandom);
        it.bits  = mask_t'($urandom);
        for (int k = 0; k < TILE; k++)
            it.acts[k] = rand_act();
        return it;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input out_row_t want);
        logic [S_TDATA_W-1:0] word;
        out_row_t             exp_row;
        word = '0;
        word[PLANE_LSB +: PLANE_W]        = it.plane;
        word[ROW_LSB +: ROW_W]            = it.wrow;
        word[BITS_LSB +: TILE]            = it.bits;
        word[ACT_LSB +: TILE * ACT_WIDTH] = it.acts;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (it.cmd == CMD_LOAD) begin
            wmask[it.plane][it.wrow] = it.bits;
        end else begin
            exp_row      = typed ? want : matmul_row(it.acts);
            pending_rows = {pending_rows, exp_row};
        end
    endtask

    // only when idle: drain results, let in-flight loads settle, then write
    task automatic write_planes(input logic [NPLANE_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        planes_cfg = v;
    endtask

    initial begin
        item_t               it;
        logic [NPLANE_W-1:0] phase_planes [N_PHASES];
        for (int p = 0; p < MAX_PLANES; p++)
            for (int k = 0; k < TILE; k++)
                wmask[p][k] = '0;
        planes_cfg   = ACTIVE_PLANES_RST;
        phase_planes = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8};
        phase_planes[4] = NPLANE_W'($urandom_range(0, 15));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_plan[i]) begin
            it.cmd   = (dir_plan[i].kind == RK_LOAD) ? CMD_LOAD : CMD_ACT;
            it.plane = dir_plan[i].plane;
            it.wrow  = dir_plan[i].wrow;
            it.bits  = dir_plan[i].bits;
            it.acts  = dir_plan[i].acts;
            if (dir_plan[i].kind == RK_CFG)
                write_planes(dir_plan[i].bits);
            else
                send_item(it, dir_plan[i].typed, dir_plan[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_planes(phase_planes[ph]);
            if (ph == N_PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item(), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_row_t want;
        out_row_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_rows.size() == 0) begin
                $error("result transaction with no expected row: %h", got);
                n_fail++;
            end else begin
                want = pending_rows.pop_front();
                for (int j = 0; j < TILE; j++) begin
                    if (got[j] !== want[j]) begin
                        $error("out%0d: expected %0d, got %0d",
                               j, $signed(want[j]), $signed(got[j]));
                        n_fail++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || cfg_wr_en)
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WATCHDOG_CYCLES) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

// ----- bit_plane_tile_matmul.f -----
hw/rtl/bptm_pkg.sv
hw/rtl/bptm_weight_store.sv
hw/rtl/bptm_lane.sv
hw/rtl/bit_plane_tile_matmul.sv
bench/tb_top.sv
